// ===== hw/rtl/memory_range_cover_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL files.
`ifndef MEMORY_RANGE_COVER_ALLOCATOR_DEFINES_SVH
`define MEMORY_RANGE_COVER_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define MRCA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("allocator check failed");

// Checked on every edge, reset included.
`define MRCA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("allocator check failed");

`else

`define MRCA_ASSERT(label, prop)
`define MRCA_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hw/rtl/mrca_pkg.sv =====
// Shared types, constants and helpers of the memory range cover allocator.
package mrca_pkg;

    localparam int REGION_SLOTS_DEF = 8;
    localparam int SLOT_HARD_CAP    = 8;

    localparam logic [31:0] ONE_MIB     = 32'h0010_0000;
    localparam logic [31:0] FILL_FIRST  = 32'd524288;   // 512 KiB
    localparam logic [31:0] FILL_SECOND = 32'd131072;   // 128 KiB
    localparam logic [31:0] LOW_BITS    = 32'h0000_0FFF;
    localparam logic [31:0] CLIP_RESET  = 32'hFFFF_FFFF;

    localparam logic [3:0]  MAX_REGIONS_RST   = 4'd6;
    localparam logic [11:0] ATTR_KEY_RST      = 12'd31;
    localparam logic [7:0]  RESERVED_TYPE_RST = 8'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_REGIONS   = 2'd0;
    localparam logic [1:0] CFG_ATTR_KEY      = 2'd1;
    localparam logic [1:0] CFG_RESERVED_TYPE = 2'd2;

    // Candidate picks
    localparam logic [1:0] PICK_NONE = 2'd0;
    localparam logic [1:0] PICK_FILL = 2'd1;
    localparam logic [1:0] PICK_UP   = 2'd2;
    localparam logic [1:0] PICK_DOWN = 2'd3;

    typedef struct packed {
        logic load_entry;
        logic load_mem;
        logic load_root;
        logic calc_up;
        logic place;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic can_place;
    } t_dp_status;

    // Largest power of two not above v, zero for zero.
    function automatic logic [31:0] pow2_floor(input logic [31:0] v);
        logic [31:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s & ~(s >> 1);
    endfunction

endpackage

// ===== hw/rtl/memory_range_cover_allocator.sv =====
// Memory range cover allocator: map intake and greedy power-of-two range placement.
// A map entry is taken when i_start is high and o_busy is low. Entries other than the
// last do not start a run, so they may follow each other on every cycle. The last
// entry starts a run: setup in ST_MEM (clip the RAM top) and ST_ROOT (find its largest
// power of two), then per placed range ST_UP (the upward candidate's priority encode)
// and ST_DECIDE (the pick); o_busy stays high until the run ends. Each range is kept
// back one round so the final result can carry the total, so results appear with one
// strobe each, the last one as o_busy falls. Results cannot be held off: every
// o_result_strobe cycle is one beat. Configuration writes are always ready and take effect
// on the next run; write them only while o_busy is low.
module memory_range_cover_allocator #(
    parameter int REGION_SLOTS = mrca_pkg::REGION_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_entry_valid,
    input  logic [63:0] i_entry_address,
    input  logic [63:0] i_entry_size,
    input  logic [7:0]  i_entry_type,
    input  logic        i_last_entry,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic        o_region_valid,
    output logic [2:0]  o_region_index,
    output logic [31:0] o_region_base_word,
    output logic [31:0] o_region_mask_word,
    output logic [3:0]  o_regions_used,
    output logic        o_last_result
);
    import mrca_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    mrca_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_last_entry (i_last_entry),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_busy       (o_busy)
    );

    mrca_datapath #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_entry_valid      (i_entry_valid),
        .i_entry_address    (i_entry_address),
        .i_entry_size       (i_entry_size),
        .i_entry_type       (i_entry_type),
        .o_result_strobe    (o_result_strobe),
        .o_region_valid     (o_region_valid),
        .o_region_index     (o_region_index),
        .o_region_base_word (o_region_base_word),
        .o_region_mask_word (o_region_mask_word),
        .o_regions_used     (o_regions_used),
        .o_last_result      (o_last_result)
    );

endmodule

// ===== hw/rtl/mrca_datapath.sv =====
// Datapath: map tracking, candidate ranges, pending and output result registers.
`include "memory_range_cover_allocator_defines.svh"

module mrca_datapath #(
    parameter int REGION_SLOTS = mrca_pkg::REGION_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrca_pkg::t_dp_cmd    i_cmd,
    output mrca_pkg::t_dp_status o_status,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [11:0]          i_cfg_data,
    input  logic                 i_entry_valid,
    input  logic [63:0]          i_entry_address,
    input  logic [63:0]          i_entry_size,
    input  logic [7:0]           i_entry_type,
    output logic                 o_result_strobe,
    output logic                 o_region_valid,
    output logic [2:0]           o_region_index,
    output logic [31:0]          o_region_base_word,
    output logic [31:0]          o_region_mask_word,
    output logic [3:0]           o_regions_used,
    output logic                 o_last_result
);
    import mrca_pkg::*;

    localparam int          SlotCap = (REGION_SLOTS < SLOT_HARD_CAP) ? REGION_SLOTS
                                                                     : SLOT_HARD_CAP;
    localparam logic [3:0]  CapBits = 4'(SlotCap);

    logic [3:0]  r_max_regions;
    logic [11:0] r_attr_key;
    logic [7:0]  r_rsv_type;

    logic [31:0] r_ram_top;
    logic [31:0] r_clip;
    logic [31:0] r_mem;
    logic [31:0] r_up_top;
    logic [31:0] r_down_base;
    logic [31:0] r_fill_floor;
    logic [31:0] r_up;
    logic [3:0]  r_count;

    logic        r_pend_valid;
    logic [2:0]  r_pend_index;
    logic [31:0] r_pend_base;
    logic [31:0] r_pend_mask;

    logic        r_strobe;
    logic        r_out_valid;
    logic [2:0]  r_out_index;
    logic [31:0] r_out_base;
    logic [31:0] r_out_mask;
    logic [3:0]  r_out_used;
    logic        r_out_last;

    logic [3:0]  w_limit;
    logic [31:0] w_start;
    logic [31:0] w_end;
    logic [31:0] w_fill;
    logic [31:0] w_down;
    logic [1:0]  w_pick;
    logic [31:0] w_base;
    logic [31:0] w_size;
    logic [31:0] w_mask;
    logic        w_in_range;

    assign w_limit    = (r_max_regions > CapBits) ? CapBits : r_max_regions;
    assign w_start    = i_entry_address[31:0];
    assign w_end      = i_entry_address[31:0] + i_entry_size[31:0];
    assign w_in_range = (i_entry_address[63:32] == 32'd0);

    always_comb begin
        w_fill = 32'd0;
        if (r_fill_floor == 32'd0) begin
            w_fill = FILL_FIRST;
        end else if (r_fill_floor == FILL_FIRST) begin
            w_fill = FILL_SECOND;
        end
        w_down = (r_down_base > ONE_MIB) ? (r_down_base >> 1) : 32'd0;

        w_pick = PICK_NONE;
        w_base = 32'd0;
        w_size = 32'd0;
        if (w_fill > r_up && w_fill > w_down) begin
            w_pick = PICK_FILL;
            w_base = r_fill_floor;
            w_size = w_fill;
        end else if (r_up > w_down) begin
            w_pick = PICK_UP;
            w_base = r_up_top;
            w_size = r_up;
        end else if (w_down != 32'd0) begin
            w_pick = PICK_DOWN;
            w_base = r_down_base - w_down;
            w_size = w_down;
        end
        w_mask = (~(w_size - 32'd1) & ~LOW_BITS) | {20'd0, r_attr_key};
    end

    assign o_status.can_place = (w_pick != PICK_NONE) && (r_count < w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_regions <= MAX_REGIONS_RST;
            r_attr_key    <= ATTR_KEY_RST;
            r_rsv_type    <= RESERVED_TYPE_RST;
            r_ram_top     <= 32'd0;
            r_clip        <= CLIP_RESET;
            r_up_top      <= 32'd0;
            r_down_base   <= 32'd0;
            r_fill_floor  <= 32'd0;
            r_count       <= 4'd0;
            r_pend_valid  <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_REGIONS:   r_max_regions <= i_cfg_data[3:0];
                    CFG_ATTR_KEY:      r_attr_key    <= i_cfg_data;
                    CFG_RESERVED_TYPE: r_rsv_type    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_cmd.load_entry && i_entry_valid && w_in_range) begin
                if (i_entry_type == r_rsv_type) begin
                    if (w_start >= ONE_MIB && w_start < r_clip) begin
                        r_clip <= w_start;
                    end
                end else if (w_start < w_end && w_end > r_ram_top) begin
                    r_ram_top <= w_end;
                end
            end

            if (i_cmd.load_mem) begin
                r_mem <= (r_ram_top > r_clip) ? r_clip : r_ram_top;
            end

            if (i_cmd.load_root) begin
                r_up_top     <= pow2_floor(r_mem);
                r_down_base  <= pow2_floor(r_mem);
                r_fill_floor <= 32'd0;
                r_count      <= 4'd0;
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.calc_up) begin
                r_up <= pow2_floor(r_mem - r_up_top);
            end

            // Hold each placed range one round so the final one can carry the totals
            if (i_cmd.place) begin
                if (r_pend_valid) begin
                    r_strobe    <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_out_index <= r_pend_index;
                    r_out_base  <= r_pend_base;
                    r_out_mask  <= r_pend_mask;
                    r_out_used  <= 4'd0;
                    r_out_last  <= 1'b0;
                end
                r_pend_valid <= 1'b1;
                r_pend_index <= r_count[2:0];
                r_pend_base  <= w_base & ~LOW_BITS;
                r_pend_mask  <= w_mask;
                r_count      <= r_count + 4'd1;
                case (w_pick)
                    PICK_FILL: r_fill_floor <= r_fill_floor + w_fill;
                    PICK_UP:   r_up_top     <= r_up_top + r_up;
                    PICK_DOWN: r_down_base  <= w_base;
                    default: ;
                endcase
            end

            if (i_cmd.finish) begin
                r_strobe     <= 1'b1;
                r_out_valid  <= r_pend_valid;
                r_out_index  <= r_pend_valid ? r_pend_index : 3'd0;
                r_out_base   <= r_pend_valid ? r_pend_base : 32'd0;
                r_out_mask   <= r_pend_valid ? r_pend_mask : 32'd0;
                r_out_used   <= r_count;
                r_out_last   <= 1'b1;
                r_pend_valid <= 1'b0;
                r_ram_top    <= 32'd0;
                r_clip       <= CLIP_RESET;
            end
        end
    end

    assign o_result_strobe    = r_strobe;
    assign o_region_valid     = r_out_valid;
    assign o_region_index     = r_out_index;
    assign o_region_base_word = r_out_base;
    assign o_region_mask_word = r_out_mask;
    assign o_regions_used     = r_out_used;
    assign o_last_result      = r_out_last;

    `MRCA_ASSERT(a_finish_clears_map, i_cmd.finish |=> (r_ram_top == 32'd0 && r_clip == CLIP_RESET))
    `MRCA_ASSERT(a_empty_only_final, (r_strobe && !r_out_valid) |-> r_out_last)
    `MRCA_ASSERT(a_place_holds_pending, i_cmd.place |=> (r_pend_valid && r_count != 4'd0))

endmodule

// ===== hw/rtl/mrca_controller.sv =====
// Controller: sequences map intake, allocation setup and the placement rounds.
`include "memory_range_cover_allocator_defines.svh"

module mrca_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_last_entry,
    input  mrca_pkg::t_dp_status i_status,
    output mrca_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);
    import mrca_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MEM    = 3'd1;
    localparam logic [2:0] ST_ROOT   = 3'd2;
    localparam logic [2:0] ST_UP     = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_entry = i_start;
                if (i_start && i_last_entry) begin
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                o_cmd.load_mem = 1'b1;
                n_state        = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.load_root = 1'b1;
                n_state         = ST_UP;
            end
            ST_UP: begin
                o_cmd.calc_up = 1'b1;
                n_state       = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.can_place) begin
                    o_cmd.place = 1'b1;
                    n_state     = ST_UP;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `MRCA_ASSERT(a_last_starts_run, (i_start && !o_busy && i_last_entry) |=> (r_state == ST_MEM))
    `MRCA_ASSERT(a_finish_frees, o_cmd.finish |=> !o_busy)
    `MRCA_ASSERT_ALWAYS(a_one_step, $onehot0({o_cmd.load_mem, o_cmd.load_root, o_cmd.calc_up, o_cmd.place, o_cmd.finish}))

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the memory range cover allocator: directed table, then random maps.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrca_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;   // unused index, writes are dropped
    localparam int         RANDOM_ITEMS  = 450;
    localparam int         SETTLE_CYCLES = 6;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [31:0] base;
        logic [31:0] mask;
        logic [3:0]  used;
        logic        last;
    } t_region;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [11:0] cfg_data;
        logic        ev;
        logic [63:0] addr;
        logic [63:0] size;
        logic [7:0]  etype;
        logic        last;
        int          typed_n;   // 0: take the predictor's regions
        t_region     typed0;
        t_region     typed1;
    } t_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_start         = 1'b0;
    logic        i_entry_valid   = 1'b0;
    logic [63:0] i_entry_address = '0;
    logic [63:0] i_entry_size    = '0;
    logic [7:0]  i_entry_type    = '0;
    logic        i_last_entry    = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [11:0] i_cfg_data      = '0;
    logic        o_busy;
    logic        o_cfg_ready;
    logic        o_result_strobe;
    logic        o_region_valid;
    logic [2:0]  o_region_index;
    logic [31:0] o_region_base_word;
    logic [31:0] o_region_mask_word;
    logic [3:0]  o_regions_used;
    logic        o_last_result;

    memory_range_cover_allocator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_entry_valid      (i_entry_valid),
        .i_entry_address    (i_entry_address),
        .i_entry_size       (i_entry_size),
        .i_entry_type       (i_entry_type),
        .i_last_entry       (i_last_entry),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_result_strobe    (o_result_strobe),
        .o_region_valid     (o_region_valid),
        .o_region_index     (o_region_index),
        .o_region_base_word (o_region_base_word),
        .o_region_mask_word (o_region_mask_word),
        .o_regions_used     (o_regions_used),
        .o_last_result      (o_last_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Allocator mirror: configuration, map state and working registers
    logic [3:0]  cfg_max       = MAX_REGIONS_RST;
    logic [11:0] cfg_key       = ATTR_KEY_RST;
    logic [7:0]  cfg_rsv       = RESERVED_TYPE_RST;
    logic [31:0] ram_top_q     = '0;
    logic [31:0] clip_q        = CLIP_RESET;
    logic [32:0] up_top_q      = '0;
    logic [31:0] down_base_q   = '0;
    logic [31:0] fill_floor_q  = '0;
    int          region_cnt_q  = 0;

    t_region     next_regions[8];
    int          next_count;
    t_region     pending_regions[$];
    int          mismatch_count = 0;
    int          items_sent;

    function automatic t_region make_region(input logic v, input logic [2:0] idx,
                                            input logic [31:0] base, input logic [31:0] mask,
                                            input logic [3:0] used, input logic last);
        t_region r;
        r.valid = v;
        r.index = idx;
        r.base  = base;
        r.mask  = mask;
        r.used  = used;
        r.last  = last;
        return r;
    endfunction

    function automatic t_row entry_row(input logic ev, input logic [63:0] addr,
                                       input logic [63:0] size, input logic [7:0] etype,
                                       input logic last, input int tn = 0,
                                       input t_region t0 = '0, input t_region t1 = '0);
        t_row r;
        r.is_cfg   = 1'b0;
        r.cfg_idx  = '0;
        r.cfg_data = '0;
        r.ev       = ev;
        r.addr     = addr;
        r.size     = size;
        r.etype    = etype;
        r.last     = last;
        r.typed_n  = tn;
        r.typed0   = t0;
        r.typed1   = t1;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [11:0] data);
        t_row r;
        r = entry_row(1'b0, '0, '0, '0, 1'b0);
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic logic [31:0] top_pow2(input logic [31:0] v);
        logic [31:0] p;
        p = '0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) p = 32'd1 << b;
        end
        return p;
    endfunction

    function automatic t_region placed(input int k, input logic [31:0] base,
                                       input logic [31:0] size);
        return make_region(1'b1, k[2:0], base & ~LOW_BITS,
                           ((~(size - 32'd1)) & ~LOW_BITS) | {20'd0, cfg_key}, 4'd0, 1'b0);
    endfunction

    // Fold one entry into the map; on the last entry plan the ranges into next_regions.
    task automatic absorb_entry(input t_row r);
        logic [31:0] start;
        logic [31:0] end_addr;
        logic [63:0] sum;
        logic [31:0] mem;
        logic [31:0] top;
        logic [31:0] up;
        logic [31:0] down;
        logic [31:0] fill;
        int          limit;
        next_count = 0;
        if (r.ev && r.addr <= 64'hFFFF_FFFF) begin
            start = r.addr[31:0];
            if (r.etype == cfg_rsv) begin
                if (start >= ONE_MIB && start < clip_q) clip_q = start;
            end else begin
                sum = r.addr + r.size;
                end_addr = sum[31:0];
                if (start < end_addr && end_addr > ram_top_q) ram_top_q = end_addr;
            end
        end
        if (!r.last) return;

        limit = cfg_max;
        if (limit > REGION_SLOTS_DEF) limit = REGION_SLOTS_DEF;
        if (limit > SLOT_HARD_CAP) limit = SLOT_HARD_CAP;
        mem = (ram_top_q > clip_q) ? clip_q : ram_top_q;
        up_top_q     = {1'b0, top_pow2(mem)};
        down_base_q  = top_pow2(mem);
        fill_floor_q = '0;
        region_cnt_q = 0;
        while (region_cnt_q < limit) begin
            top  = up_top_q[31:0];
            up   = top_pow2(mem - top);
            down = (down_base_q <= ONE_MIB) ? 32'd0 : down_base_q >> 1;
            if (fill_floor_q == 0) fill = FILL_FIRST;
            else if (fill_floor_q == FILL_FIRST) fill = FILL_SECOND;
            else fill = 32'd0;
            if (fill > up && fill > down) begin
                next_regions[region_cnt_q] = placed(region_cnt_q, fill_floor_q, fill);
                fill_floor_q = fill_floor_q + fill;
            end else if (up > down) begin
                next_regions[region_cnt_q] = placed(region_cnt_q, top, up);
                up_top_q = {1'b0, top} + {1'b0, up};
            end else if (down != 0) begin
                down_base_q = down_base_q - down;
                next_regions[region_cnt_q] = placed(region_cnt_q, down_base_q, down);
            end else begin
                break;
            end
            region_cnt_q++;
        end
        ram_top_q = '0;
        clip_q    = CLIP_RESET;

        if (region_cnt_q == 0) begin
            next_regions[0] = make_region(1'b0, '0, '0, '0, '0, 1'b1);
            next_count = 1;
        end else begin
            next_regions[region_cnt_q - 1].used = region_cnt_q[3:0];
            next_regions[region_cnt_q - 1].last = 1'b1;
            next_count = region_cnt_q;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_region want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_regions.size() == 0) begin
                report_mismatch("unexpected result beat", {32'd0, o_region_base_word}, 64'd0);
            end else begin
                want = pending_regions.pop_front();
                if (o_region_valid !== want.valid)
                    report_mismatch("region_valid", o_region_valid, want.valid);
                if (o_region_index !== want.index)
                    report_mismatch("region_index", o_region_index, want.index);
                if (o_region_base_word !== want.base)
                    report_mismatch("region_base_word", o_region_base_word, want.base);
                if (o_region_mask_word !== want.mask)
                    report_mismatch("region_mask_word", o_region_mask_word, want.mask);
                if (o_regions_used !== want.used)
                    report_mismatch("regions_used", o_regions_used, want.used);
                if (o_last_result !== want.last)
                    report_mismatch("last_result", o_last_result, want.last);
            end
        end
    end

    // Present one entry and hold it until the block takes the beat.
    task automatic send_entry(input t_row r);
        i_start         <= 1'b1;
        i_entry_valid   <= r.ev;
        i_entry_address <= r.addr;
        i_entry_size    <= r.size;
        i_entry_type    <= r.etype;
        i_last_entry    <= r.last;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        absorb_entry(r);
        if (r.typed_n == 0) begin
            for (int k = 0; k < next_count; k++) pending_regions.push_back(next_regions[k]);
        end else begin
            pending_regions.push_back(r.typed0);
            if (r.typed_n > 1) pending_regions.push_back(r.typed1);
        end
    endtask

    task automatic pause_start(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 3) == 0) pause_start($urandom_range(1, 12));
    endtask

    // Drop start and wait out every pending region plus the tail of the run.
    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_regions.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [11:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_MAX_REGIONS:   cfg_max = data[3:0];
            CFG_ATTR_KEY:      cfg_key = data;
            CFG_RESERVED_TYPE: cfg_rsv = data[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [3:0]  max4;
        logic [11:0] key;
        logic [7:0]  rsv;
        max4 = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(5, 8));
        set_register(CFG_MAX_REGIONS, {8'($urandom()), max4});
        case ($urandom_range(0, 3))
            0:       key = 12'h000;
            1:       key = 12'hFFF;
            default: key = 12'($urandom());
        endcase
        set_register(CFG_ATTR_KEY, key);
        rsv = $urandom_range(0, 1) ? RESERVED_TYPE_RST : 8'($urandom());
        set_register(CFG_RESERVED_TYPE, {4'($urandom()), rsv});
        if ($urandom_range(0, 3) == 0) set_register(CFG_SPARE, 12'($urandom()));
    endtask

    // One map of 1..6 entries; mostly plausible layouts, now and then raw noise.
    task automatic random_map(input bit steady);
        int          n;
        bit          noise;
        logic        ev;
        logic [63:0] addr;
        logic [63:0] size;
        logic [7:0]  etype;
        n = $urandom_range(1, 6);
        noise = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++) begin
            ev = ($urandom_range(0, 19) != 0);
            if (noise) begin
                addr  = {$urandom(), $urandom()};
                size  = {$urandom(), $urandom()};
                etype = 8'($urandom());
            end else begin
                case ($urandom_range(0, 3))
                    0:       addr = 64'($urandom_range(0, ONE_MIB));
                    1:       addr = {32'd0, $urandom() & ~LOW_BITS};
                    2:       addr = {32'd0, $urandom() >> $urandom_range(0, 12)};
                    default: addr = 64'd0;
                endcase
                if ($urandom_range(0, 15) == 0) addr[63:32] = $urandom();
                size = {32'd0, $urandom() >> $urandom_range(0, 24)};
                if ($urandom_range(0, 15) == 0) size[63:32] = $urandom();
                etype = ($urandom_range(0, 4) == 0) ? cfg_rsv : 8'($urandom());
            end
            if (!steady) maybe_pause();
            send_entry(entry_row(ev, addr, size, etype, k == n - 1));
        end
        items_sent += n;
    endtask

    initial begin
        t_row    steps[$];
        t_region fill_lo;
        t_region fill_hi;
        int      maps;

        // Empty map with the reset key: only the two low fill ranges fit
        fill_lo = make_region(1'b1, 3'd0, 32'h0000_0000, 32'hFFF8_001F, 4'd0, 1'b0);
        fill_hi = make_region(1'b1, 3'd1, 32'h0008_0000, 32'hFFFE_001F, 4'd2, 1'b1);

        steps.push_back(entry_row(1'b0, 64'd0, 64'd0, 8'd0, 1'b1, 2, fill_lo, fill_hi));
        steps.push_back(entry_row(1'b1, 64'h1_0000_0000, 64'h10_0000, 8'd1, 1'b1,
                                  2, fill_lo, fill_hi));
        steps.push_back(entry_row(1'b1, 64'hFFFF_F000, 64'h1000, 8'd1, 1'b1,
                                  2, fill_lo, fill_hi));
        steps.push_back(entry_row(1'b1, '1, '1, 8'hFF, 1'b0));
        steps.push_back(entry_row(1'b1, 64'd0, 64'hFFFF_FFFF, 8'd1, 1'b1));
        steps.push_back(entry_row(1'b1, 64'd0, 64'h0400_0000, 8'd1, 1'b0));
        steps.push_back(entry_row(1'b1, 64'h0300_0000, 64'h1000, 8'd2, 1'b0));
        steps.push_back(entry_row(1'b1, 64'h0008_0000, 64'h1000, 8'd2, 1'b1));
        steps.push_back(entry_row(1'b1, 64'h1000_0000, 64'h1_1000_0000, 8'h7F, 1'b1));
        steps.push_back(cfg_row(CFG_MAX_REGIONS, 12'd1));
        steps.push_back(entry_row(1'b0, 64'd0, 64'd0, 8'd0, 1'b1, 1,
                                  make_region(1'b1, 3'd0, 32'd0, 32'hFFF8_001F, 4'd1, 1'b1)));
        steps.push_back(entry_row(1'b1, 64'd0, 64'h1000_0000, 8'd1, 1'b1));
        steps.push_back(cfg_row(CFG_MAX_REGIONS, 12'd0));
        steps.push_back(entry_row(1'b0, 64'd0, 64'd0, 8'd0, 1'b1, 1,
                                  make_region(1'b0, 3'd0, 32'd0, 32'd0, 4'd0, 1'b1)));
        steps.push_back(cfg_row(CFG_MAX_REGIONS, 12'hFFF));
        steps.push_back(cfg_row(CFG_ATTR_KEY, 12'hFFF));
        steps.push_back(cfg_row(CFG_RESERVED_TYPE, 12'hFFF));
        steps.push_back(entry_row(1'b1, 64'd0, 64'h7FFF_F000, 8'd1, 1'b0));
        steps.push_back(entry_row(1'b1, 64'h7000_0000, 64'd0, 8'hFF, 1'b0));
        steps.push_back(entry_row(1'b1, 64'h1000, '1, 8'd0, 1'b1));
        steps.push_back(cfg_row(CFG_SPARE, 12'hFFF));
        steps.push_back(cfg_row(CFG_MAX_REGIONS, 12'hFF8));
        steps.push_back(cfg_row(CFG_ATTR_KEY, 12'h000));
        steps.push_back(cfg_row(CFG_RESERVED_TYPE, 12'h000));
        steps.push_back(entry_row(1'b1, 64'h0010_0000, 64'h10, 8'd0, 1'b0));
        steps.push_back(entry_row(1'b1, 64'd0, 64'h0F00_0000, 8'd1, 1'b1));
        steps.push_back(entry_row(1'b0, 64'hDEAD_BEEF, 64'h1234_5678, 8'hAB, 1'b0));
        steps.push_back(entry_row(1'b1, 64'h0012_3456, 64'h0ABC_DEF0, 8'h55, 1'b1));
        steps.push_back(cfg_row(CFG_MAX_REGIONS, 12'd6));
        steps.push_back(cfg_row(CFG_ATTR_KEY, 12'h5A5));
        steps.push_back(cfg_row(CFG_RESERVED_TYPE, 12'd2));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[s]) begin
            if (steps[s].is_cfg) begin
                set_register(steps[s].cfg_idx, steps[s].cfg_data);
            end else begin
                maybe_pause();
                send_entry(steps[s]);
            end
        end

        // Random maps; reprogram between every few, no idling in the tail
        items_sent = 0;
        maps = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (maps % 8 == 7) random_config();
            random_map(items_sent > RANDOM_ITEMS * 4 / 5);
            maps++;
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mrca_pkg.sv
hw/rtl/mrca_datapath.sv
hw/rtl/mrca_controller.sv
hw/rtl/memory_range_cover_allocator.sv
tb/sv/testbench.sv
